// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the slot list block.
// Depends on nothing; included by the checker file by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define OKS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define OKS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/okslt_pkg.sv
// Shared types and constants of the ordered keyed slot list block.
// Depends on nothing; used by every module of the block.
package okslt_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KEY_W    = 32;
   localparam int COORD_W  = 16;
   localparam int HANDLE_W = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
   localparam logic             KIND_RESET = 1'b0;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_KIND = 2'd3;

   localparam logic REG_CAPACITY  = 1'b0;
   localparam logic REG_DATA_KIND = 1'b1;

   localparam logic KIND_COORD = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_FIND  = 2'd1,
      FUNC_PULL  = 2'd2,
      FUNC_PUSH  = 2'd3
   } func_type;

   typedef struct packed {
      logic        [KEY_W-1:0]    key;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic        [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic compare;
      logic remove;
      logic load;
      logic load_coord;
   } cell_ctl_type;

   typedef struct packed {
      logic [CAP_W-1:0] capacity;
      logic             data_kind;
   } csr_cfg_type;

endpackage

// File: hw/rtl/okslt_csr.sv
// Configuration registers (capacity, data kind) behind the APB-style port.
// Depends on okslt_pkg.
module okslt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [okslt_pkg::ADDR_W-1:0]        paddr,
   input  logic [okslt_pkg::DATA_W-1:0]        pwdata,
   output logic [okslt_pkg::DATA_W-1:0]        prdata,
   output logic                                pready,
   output okslt_pkg::csr_cfg_type              cfg
);

   okslt_pkg::csr_cfg_type cfg_ff;
   okslt_pkg::csr_cfg_type cfg_in;
   logic                   wr_en;
   logic                   reg_index;

   assign wr_en     = psel && penable && pwrite;
   assign reg_index = paddr[2];
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            okslt_pkg::REG_CAPACITY: begin
               cfg_in.capacity = pwdata[okslt_pkg::CAP_W-1:0];
            end
            okslt_pkg::REG_DATA_KIND: begin
               cfg_in.data_kind = pwdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         okslt_pkg::REG_CAPACITY: begin
            prdata = okslt_pkg::DATA_W'(cfg_ff.capacity);
         end
         okslt_pkg::REG_DATA_KIND: begin
            prdata = okslt_pkg::DATA_W'(cfg_ff.data_kind);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity  <= okslt_pkg::CAP_RESET;
         cfg_ff.data_kind <= okslt_pkg::KIND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/okslt_cell.sv
// One slot of the list: holds an entry, compares its key and shifts down.
// Depends on okslt_pkg; instantiated in a row by the top level.
module okslt_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 5,
   parameter int IW    = 4
) (
   input  logic                              clock,
   input  okslt_pkg::cell_ctl_type           ctl,
   input  logic [okslt_pkg::KEY_W-1:0]       cmp_key,
   input  logic [CW-1:0]                     count,
   input  logic [CW-1:0]                     load_at,
   input  okslt_pkg::entry_type              load_entry,
   input  okslt_pkg::entry_type              next_entry,
   input  logic                              seen_in,
   input  logic [IW-1:0]                     pos_in,
   output okslt_pkg::entry_type              entry,
   output logic                              seen_out,
   output logic [IW-1:0]                     pos_out
);

   okslt_pkg::entry_type entry_ff;
   okslt_pkg::entry_type entry_in;
   logic                 match_ff;
   logic                 match_in;
   logic                 occupied;
   logic                 shift;
   logic                 load_here;

   assign occupied  = CW'(INDEX) < count;
   assign seen_out  = seen_in | match_ff;
   assign pos_out   = match_ff ? IW'(INDEX) : pos_in;
   assign shift     = ctl.remove && seen_out;
   assign load_here = ctl.load && (load_at == CW'(INDEX));
   assign entry     = entry_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.compare) begin
         match_in = occupied && (entry_ff.key == cmp_key);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (load_here) begin
         entry_in.key = load_entry.key;
         if (ctl.load_coord) begin
            entry_in.x = load_entry.x;
            entry_in.y = load_entry.y;
         end else begin
            entry_in.handle = load_entry.handle;
         end
      end else if (shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

endmodule

// File: hw/rtl/ordered_keyed_slot_list_core.sv
// Ordered keyed slot list: a row of DEPTH slots kept in arrival order, searched by a 32-bit key.
// In the cycle an item is accepted every slot compares its key, and in the next cycle, the
// execute state, the row shifts to close a gap and the new entry is written, while the result
// is registered. The next item is accepted once the block is back in idle and the result
// register is free or being emptied. Keys in the list are unique, so a hit and its position
// ripple along the row of slots. Configuration must be written through the APB-style port
// while no item is in flight; the block itself does not enforce this.
// Depends on okslt_pkg, okslt_csr and okslt_cell.
module ordered_keyed_slot_list_core #(
   parameter int DEPTH = okslt_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [okslt_pkg::FUNC_W-1:0]          req_func,
   input  logic [okslt_pkg::KEY_W-1:0]           req_key,
   input  logic                                  req_push_kind,
   input  logic signed [okslt_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [okslt_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [okslt_pkg::HANDLE_W-1:0]        req_handle,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [okslt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [okslt_pkg::POS_W-1:0]           rsp_position,
   output logic [okslt_pkg::COUNT_W-1:0]         rsp_count,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [okslt_pkg::ADDR_W-1:0]          paddr,
   input  logic [okslt_pkg::DATA_W-1:0]          pwdata,
   output logic [okslt_pkg::DATA_W-1:0]          prdata,
   output logic                                  pready
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = (CW > okslt_pkg::POS_W) ? CW : okslt_pkg::POS_W;
   localparam int RW = (CW > okslt_pkg::COUNT_W) ? CW : okslt_pkg::COUNT_W;
   localparam int EW = (CW > okslt_pkg::CAP_W) ? CW : okslt_pkg::CAP_W;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   okslt_pkg::csr_cfg_type  cfg;
   okslt_pkg::cell_ctl_type ctl;
   okslt_pkg::entry_type    load_ff;
   okslt_pkg::entry_type    entries [DEPTH];
   okslt_pkg::func_type     func_ff;
   logic                    push_kind_ff;
   logic                    seen_chain [DEPTH+1];
   logic [IW-1:0]           pos_chain [DEPTH+1];

   state_type                        state_ff;
   state_type                        state_in;
   logic [CW-1:0]                    count_ff;
   logic [CW-1:0]                    count_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [okslt_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [okslt_pkg::STATUS_W-1:0]   rsp_status_in;
   logic [PW-1:0]                    rsp_pos_ff;
   logic [PW-1:0]                    rsp_pos_in;

   logic          accept;
   logic          hit;
   logic [CW-1:0] cnt_after;
   logic [CW-1:0] load_at;
   logic [EW-1:0] cap_ext;
   logic [EW-1:0] eff_cap;
   logic [RW-1:0] count_ext;

   okslt_csr u_okslt_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign seen_chain[0] = 1'b0;
   assign pos_chain[0]  = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      okslt_pkg::entry_type next_entry;
      if (i == DEPTH - 1) begin : g_last
         assign next_entry = entries[i];
      end else begin : g_mid
         assign next_entry = entries[i+1];
      end
      okslt_cell #(
         .INDEX (i),
         .CW    (CW),
         .IW    (IW)
      ) u_okslt_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cmp_key    (req_key),
         .count      (count_ff),
         .load_at    (load_at),
         .load_entry (load_ff),
         .next_entry (next_entry),
         .seen_in    (seen_chain[i]),
         .pos_in     (pos_chain[i]),
         .entry      (entries[i]),
         .seen_out   (seen_chain[i+1]),
         .pos_out    (pos_chain[i+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign hit       = seen_chain[DEPTH];
   assign cnt_after = count_ff - CW'(hit);
   assign load_at   = cnt_after;
   assign cap_ext   = EW'(cfg.capacity);

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_pos_in     = rsp_pos_ff;
      ctl.compare    = accept;
      ctl.remove     = 1'b0;
      ctl.load       = 1'b0;
      ctl.load_coord = (push_kind_ff == okslt_pkg::KIND_COORD);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = okslt_pkg::STATUS_OK;
            rsp_pos_in    = '0;
            case (func_ff)
               okslt_pkg::FUNC_CLEAR: begin
                  count_in = '0;
               end
               okslt_pkg::FUNC_FIND: begin
                  if (hit) begin
                     rsp_pos_in = PW'(pos_chain[DEPTH]);
                  end else begin
                     rsp_status_in = okslt_pkg::STATUS_MISS;
                  end
               end
               okslt_pkg::FUNC_PULL: begin
                  if (hit) begin
                     rsp_pos_in = PW'(pos_chain[DEPTH]);
                     ctl.remove = 1'b1;
                     count_in   = cnt_after;
                  end else begin
                     rsp_status_in = okslt_pkg::STATUS_MISS;
                  end
               end
               okslt_pkg::FUNC_PUSH: begin
                  if (push_kind_ff != cfg.data_kind) begin
                     rsp_status_in = okslt_pkg::STATUS_KIND;
                  end else begin
                     ctl.remove = 1'b1;
                     if (EW'(cnt_after) >= eff_cap) begin
                        rsp_status_in = okslt_pkg::STATUS_FULL;
                        count_in      = cnt_after;
                     end else begin
                        ctl.load   = 1'b1;
                        rsp_pos_in = PW'(cnt_after);
                        count_in   = cnt_after + CW'(1);
                     end
                  end
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff        <= okslt_pkg::func_type'(req_func);
         push_kind_ff   <= req_push_kind;
         load_ff.key    <= req_key;
         load_ff.x      <= req_coord_x;
         load_ff.y      <= req_coord_y;
         load_ff.handle <= req_handle;
      end
   end

   assign count_ext    = RW'(count_ff);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff[okslt_pkg::POS_W-1:0];
   assign rsp_count    = count_ext[okslt_pkg::COUNT_W-1:0];

endmodule

// File: hw/rtl/okslt_checker.sv
// Port-level assertions for the ordered keyed slot list block, bound to the top level.
// Depends on okslt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module okslt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [okslt_pkg::FUNC_W-1:0]       req_func,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [okslt_pkg::STATUS_W-1:0]     rsp_status,
   input logic [okslt_pkg::POS_W-1:0]        rsp_position,
   input logic [okslt_pkg::COUNT_W-1:0]      rsp_count
);

   `OKS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result offered after reset")

   `OKS_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "item accepted while busy")

   `OKS_ASSERT(a_clear_result, clock, reset, req_valid && req_ready && req_func == okslt_pkg::FUNC_CLEAR |-> ##2 (rsp_valid && rsp_count == 0 && rsp_status == okslt_pkg::STATUS_OK), "clear did not empty the list")

   `OKS_ASSERT(a_fail_pos_zero, clock, reset, rsp_valid && rsp_status != okslt_pkg::STATUS_OK |-> rsp_position == 0, "failed item reports a position")

   `OKS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count), "stalled result changed")

endmodule

bind ordered_keyed_slot_list_core okslt_checker u_okslt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position),
   .rsp_count    (rsp_count)
);
